// File: rtl/shf_pkg.sv
package shf_pkg;

  localparam int unsigned HashW     = 32;
  localparam int unsigned CountW    = 3;
  localparam int unsigned TdataInW  = 72;
  localparam int unsigned TdataOutW = 32;
  localparam int unsigned FifoDepth = 2;

  localparam logic [CountW-1:0] CntOne   = 3'd1;
  localparam logic [CountW-1:0] CntTwo   = 3'd2;
  localparam logic [CountW-1:0] CntThree = 3'd3;

  // front sequencer: run, or rebuild the running hash after a final word
  typedef enum logic [2:0] {
    ST_RUN    = 3'b001,
    ST_AVAL_A = 3'b010,
    ST_AVAL_B = 3'b100
  } front_state_e;

  // full-word round
  function automatic logic [HashW-1:0] mix_word(logic [HashW-1:0] h, logic [HashW-1:0] w);
    logic [HashW-1:0] h1;
    logic [HashW-1:0] t;
    logic [HashW-1:0] h2;
    h1 = h + {16'd0, w[15:0]};
    t  = {5'd0, w[31:16], 11'd0} ^ h1;
    h2 = {h1[15:0], 16'd0} ^ t;
    return h2 + (h2 >> 11);
  endfunction

  // tail round for 1 to 3 bytes, nothing for no bytes
  function automatic logic [HashW-1:0] mix_tail(logic [HashW-1:0] h, logic [HashW-1:0] w,
                                                logic [CountW-1:0] n);
    logic [HashW-1:0] r;
    r = h;
    case (n)
      CntThree: begin
        r = h + {16'd0, w[15:0]};
        r = r ^ (r << 16);
        r = r ^ {6'd0, w[23:16], 18'd0};
        r = r + (r >> 11);
      end
      CntTwo: begin
        r = h + {16'd0, w[15:0]};
        r = r ^ (r << 11);
        r = r + (r >> 17);
      end
      CntOne: begin
        r = h + {24'd0, w[7:0]};
        r = r ^ (r << 10);
        r = r + (r >> 1);
      end
      default: r = h;
    endcase
    return r;
  endfunction

  // first half of the final avalanche
  function automatic logic [HashW-1:0] aval_a(logic [HashW-1:0] h);
    logic [HashW-1:0] r;
    r = h ^ (h << 3);
    r = r + (r >> 5);
    r = r ^ (r << 4);
    return r;
  endfunction

  // second half of the final avalanche
  function automatic logic [HashW-1:0] aval_b(logic [HashW-1:0] h);
    logic [HashW-1:0] r;
    r = h + (h >> 17);
    r = r ^ (r << 25);
    r = r + (r >> 6);
    return r;
  endfunction

endpackage

// File: rtl/shf_front.sv
module shf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [shf_pkg::HashW-1:0]   word_i,
  input  logic [shf_pkg::CountW-1:0]  count_i,
  input  logic                        first_i,
  input  logic                        last_i,
  input  logic [shf_pkg::HashW-1:0]   seed_i,
  input  logic                        q_ready_i,
  output logic                        push_o,
  output logic [shf_pkg::HashW-1:0]   push_data_o
);

  shf_pkg::front_state_e state_q, state_d;
  logic [shf_pkg::HashW-1:0] hash_q, hash_d;
  logic [shf_pkg::HashW-1:0] base;
  logic [shf_pkg::HashW-1:0] mixed;
  logic [shf_pkg::HashW-1:0] pre;
  logic                      accept;
  logic                      full_word;

  // a first word never needs the running hash, so it may pass while it is rebuilt
  assign in_ready_o = q_ready_i && ((state_q == shf_pkg::ST_RUN) || (in_valid_i && first_i));
  assign accept     = in_valid_i && in_ready_o;

  assign base      = first_i ? seed_i : hash_q;
  assign full_word = !last_i || count_i[2];
  assign mixed     = full_word ? shf_pkg::mix_word(base, word_i)
                               : shf_pkg::mix_tail(base, word_i, count_i);
  // empty message: zero survives the avalanche unchanged
  assign pre       = (first_i && last_i && (count_i == '0)) ? '0 : mixed;

  assign push_o      = accept && last_i;
  assign push_data_o = pre;

  always_comb begin
    state_d = state_q;
    hash_d  = hash_q;
    if (accept) begin
      hash_d  = pre;
      state_d = last_i ? shf_pkg::ST_AVAL_A : shf_pkg::ST_RUN;
    end else begin
      case (state_q)
        shf_pkg::ST_AVAL_A: begin
          hash_d  = shf_pkg::aval_a(hash_q);
          state_d = shf_pkg::ST_AVAL_B;
        end
        shf_pkg::ST_AVAL_B: begin
          hash_d  = shf_pkg::aval_b(hash_q);
          state_d = shf_pkg::ST_RUN;
        end
        default: begin
          hash_d  = hash_q;
          state_d = shf_pkg::ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= shf_pkg::ST_RUN;
      hash_q  <= '0;
    end else begin
      state_q <= state_d;
      hash_q  <= hash_d;
    end
  end

endmodule

// File: rtl/shf_fifo.sv
module shf_fifo #(
  parameter int unsigned Depth = shf_pkg::FifoDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [shf_pkg::HashW-1:0]  push_data_i,
  output logic                       ready_o,
  output logic                       valid_o,
  output logic [shf_pkg::HashW-1:0]  data_o,
  input  logic                       pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [shf_pkg::HashW-1:0] mem_q [Depth];
  logic [shf_pkg::HashW-1:0] data_q;
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PtrW-1:0] rd_nxt;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign ready_o = cnt_q != CntW'(Depth);
  assign valid_o = cnt_q != '0;
  assign data_o  = data_q;
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;
  assign rd_nxt  = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;

  // head word kept in its own register, loaded on push into an empty queue or on pop
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
    if (do_push && ((cnt_q == '0) || (do_pop && (cnt_q == CntW'(1))))) begin
      data_q <= push_data_i;
    end else if (do_pop) begin
      data_q <= mem_q[rd_nxt];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_nxt;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: rtl/shf_back.sv
module shf_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [shf_pkg::HashW-1:0]  in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [shf_pkg::HashW-1:0]  out_data_o
);

  logic                      s1_valid_q;
  logic [shf_pkg::HashW-1:0] s1_data_q;
  logic                      out_valid_q;
  logic [shf_pkg::HashW-1:0] out_data_q;
  logic                      out_free;
  logic                      s1_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_ready_o = s1_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i) begin
    if (s1_free && in_valid_i) begin
      s1_data_q <= shf_pkg::aval_a(in_data_i);
    end
    if (out_free && s1_valid_q) begin
      out_data_q <= shf_pkg::aval_b(s1_data_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

endmodule

// File: rtl/superfast_hash_stream.sv
// channel  | dir | handshake             | payload
// s_axis   | in  | s_axis_tvalid/tready  | tdata: word, count, seed; tuser: first; tlast: last
// m_axis   | out | m_axis_tvalid/tready  | tdata: hash value
//
// one word per cycle in a message while the queue has room; front unit rounds are combinational
// after a final word a following non-first word waits while the front unit
//   rebuilds the running hash through its two avalanche steps; a first word goes on at once
// a final word's result passes the queue, the avalanche stage and the output register
// reset clears the running hash to zero and empties the queue and the back pipeline
// output stalls back up through the queue into s_axis_tready only once the queue is full
module superfast_hash_stream #(
  parameter int unsigned FifoDepth = shf_pkg::FifoDepth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] data_word, [34:32] byte_count, [66:35] seed, [71:67] zero
  input  logic [shf_pkg::TdataInW-1:0]    s_axis_tdata,
  // [0] first
  input  logic                            s_axis_tuser,
  input  logic                            s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [31:0] hash_value
  output logic [shf_pkg::TdataOutW-1:0]   m_axis_tdata
);

  // queue side signals between the front and back units
  logic                      q_ready;
  logic                      push;
  logic [shf_pkg::HashW-1:0] push_data;
  logic                      q_valid;
  logic [shf_pkg::HashW-1:0] q_data;
  logic                      q_pop;

  // front: runs the hash recurrence, pushes the pre-avalanche value of each final word
  shf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .word_i      (s_axis_tdata[31:0]),
    .count_i     (s_axis_tdata[34:32]),
    .first_i     (s_axis_tuser),
    .last_i      (s_axis_tlast),
    .seed_i      (s_axis_tdata[66:35]),
    .q_ready_i   (q_ready),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // short queue so front and back stall independently
  shf_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (q_pop)
  );

  // back: two-stage avalanche ending in the output register
  shf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_pop),
    .in_data_i   (q_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: tb/superfast_hash_stream_test.sv
module superfast_hash_stream_test;

  localparam logic [shf_pkg::CountW-1:0] NoBytes   = 3'd0;
  localparam logic [shf_pkg::CountW-1:0] FullCount = 3'd4;
  localparam int unsigned StallLimit = 2000;  // cycles with no word moving on either side
  localparam int unsigned TrailCycles = 8;    // idle cycles run after the last expected hash
  localparam int unsigned PhaseTwoAt = 350;   // input words accepted before swapping idle rates
  localparam int unsigned PhaseThreeAt = 700; // input words accepted before idling stops

  // one input word as the driver sees it, plus a hold-off flag
  typedef struct packed {
    logic [shf_pkg::HashW-1:0]  data;
    logic [shf_pkg::CountW-1:0] count;
    logic                       first;
    logic                       last;
    logic [shf_pkg::HashW-1:0]  seed;
    logic                       hold;  // wait until every pending hash is out before sending
  } msg_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  // [31:0] data_word, [34:32] byte_count, [66:35] seed, [71:67] zero
  logic [shf_pkg::TdataInW-1:0]   s_axis_tdata = '0;
  // [0] first
  logic                           s_axis_tuser = 1'b0;
  logic                           s_axis_tlast = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // [31:0] hash_value
  logic [shf_pkg::TdataOutW-1:0]  m_axis_tdata;

  msg_word_t                 word_q[$];   // words still to be sent
  logic [shf_pkg::HashW-1:0] hash_q[$];   // hashes still to come out, oldest first
  msg_word_t                 on_bus;      // word currently offered on s_axis
  logic [shf_pkg::HashW-1:0] model_hash = '0;
  int unsigned               words_in = 0;
  int unsigned               err_cnt = 0;
  int unsigned               quiet_cycles = 0;

  superfast_hash_stream u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // hash prediction
  // ---------------------------------------------------------------------------

  // four-byte round: low half added, high half folded in above bit 11
  function automatic logic [shf_pkg::HashW-1:0] round_full(logic [shf_pkg::HashW-1:0] h,
                                                           logic [shf_pkg::HashW-1:0] w);
    logic [shf_pkg::HashW-1:0] t;
    h = h + shf_pkg::HashW'(w[15:0]);
    t = (shf_pkg::HashW'(w[31:16]) << 11) ^ h;
    h = (h << 16) ^ t;
    return h + (h >> 11);
  endfunction

  // tail round for a final word with 1 to 3 bytes; no bytes leaves the hash alone
  function automatic logic [shf_pkg::HashW-1:0] round_tail(logic [shf_pkg::HashW-1:0] h,
                                                           logic [shf_pkg::HashW-1:0] w,
                                                           logic [shf_pkg::CountW-1:0] n);
    case (n)
      shf_pkg::CntThree: begin
        h = h + shf_pkg::HashW'(w[15:0]);
        h = h ^ (h << 16);
        h = h ^ (shf_pkg::HashW'(w[23:16]) << 18);
        h = h + (h >> 11);
      end
      shf_pkg::CntTwo: begin
        h = h + shf_pkg::HashW'(w[15:0]);
        h = h ^ (h << 11);
        h = h + (h >> 17);
      end
      shf_pkg::CntOne: begin
        h = h + shf_pkg::HashW'(w[7:0]);
        h = h ^ (h << 10);
        h = h + (h >> 1);
      end
      default: ;
    endcase
    return h;
  endfunction

  // six-step final avalanche
  function automatic logic [shf_pkg::HashW-1:0] avalanche_mix(logic [shf_pkg::HashW-1:0] h);
    h = h ^ (h << 3);
    h = h + (h >> 5);
    h = h ^ (h << 4);
    h = h + (h >> 17);
    h = h ^ (h << 25);
    h = h + (h >> 6);
    return h;
  endfunction

  // fold one accepted word into the running hash, queue the hash a final word yields
  function automatic void absorb_word(msg_word_t wd);
    logic [shf_pkg::HashW-1:0]  h;
    logic [shf_pkg::CountW-1:0] n;
    n = (wd.count > FullCount || !wd.last) ? FullCount : wd.count;
    h = wd.first ? wd.seed : model_hash;
    if (!wd.last) begin
      model_hash = round_full(h, wd.data);
    end else if (wd.first && n == NoBytes) begin
      // empty message hashes to zero
      model_hash = '0;
      hash_q.push_back('0);
    end else begin
      h = (n == FullCount) ? round_full(h, wd.data) : round_tail(h, wd.data, n);
      model_hash = avalanche_mix(h);
      hash_q.push_back(model_hash);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void add_word(logic [shf_pkg::HashW-1:0] data,
                                   logic [shf_pkg::CountW-1:0] count,
                                   logic first, logic last, logic [shf_pkg::HashW-1:0] seed,
                                   logic hold = 1'b0);
    msg_word_t wd;
    wd.data  = data;
    wd.count = count;
    wd.first = first;
    wd.last  = last;
    wd.seed  = seed;
    wd.hold  = hold;
    word_q.push_back(wd);
  endfunction

  // mostly random, with all-zero and all-one words mixed in
  function automatic logic [shf_pkg::HashW-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(19, 0);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom();
  endfunction

  // idle rates by phase: sender 22/receiver 69, then swapped, then none
  function automatic int unsigned sender_idle_pct();
    if (words_in < PhaseTwoAt) return 22;
    if (words_in < PhaseThreeAt) return 69;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    if (words_in < PhaseTwoAt) return 69;
    if (words_in < PhaseThreeAt) return 22;
    return 0;
  endfunction

  task automatic report_error(string what, logic [shf_pkg::HashW-1:0] got,
                              logic [shf_pkg::HashW-1:0] want);
    $display("ERROR %0t: %s: got %08h, expected %08h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // ---------------------------------------------------------------------------
  // s_axis driver: one word offered at a time, held until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_blk
    logic      took;
    logic      send;
    msg_word_t nxt;
    if (rst_ni) begin
      took = s_axis_tvalid && s_axis_tready;
      if (took) begin
        absorb_word(on_bus);
        words_in <= words_in + 1;
      end
      if (!s_axis_tvalid || took) begin
        send = word_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct();
        // hold-off: let the pipeline drain completely before this word
        if (send && word_q[0].hold && hash_q.size() != 0) send = 1'b0;
        if (send) begin
          nxt = word_q.pop_front();
          on_bus        <= nxt;
          s_axis_tdata  <= {5'd0, nxt.seed, nxt.count, nxt.data};
          s_axis_tuser  <= nxt.first;
          s_axis_tlast  <= nxt.last;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // m_axis monitor: every hash taken is checked against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_blk
    logic [shf_pkg::HashW-1:0] want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (hash_q.size() == 0) begin
          report_error("hash with no message pending", m_axis_tdata, '0);
        end else begin
          want = hash_q.pop_front();
          if (m_axis_tdata !== want) report_error("hash_value", m_axis_tdata, want);
        end
      end
      m_axis_tready <= ($urandom_range(99, 0) >= receiver_idle_pct());
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no word moving on either side
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("superfast_hash_stream_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned                len;
    logic                       noisy;
    logic [shf_pkg::CountW-1:0] cnt;

    // no first straight after reset: continues from a zero running hash
    add_word('0, FullCount, 1'b0, 1'b0, '1);
    add_word('1, FullCount, 1'b0, 1'b1, '1);
    // empty message
    add_word($urandom(), NoBytes, 1'b1, 1'b1, $urandom());
    // single full words at the extremes
    add_word('1, FullCount, 1'b1, 1'b1, '1);
    add_word('0, FullCount, 1'b1, 1'b1, '0);
    // one-word tails, junk in the unused bytes
    add_word('1, shf_pkg::CntOne, 1'b1, 1'b1, $urandom());
    add_word('1, shf_pkg::CntTwo, 1'b1, 1'b1, $urandom());
    add_word('1, shf_pkg::CntThree, 1'b1, 1'b1, $urandom());
    // oversized counts act as four bytes
    add_word($urandom(), 3'd5, 1'b1, 1'b1, $urandom());
    add_word($urandom(), 3'd6, 1'b1, 1'b1, $urandom());
    add_word($urandom(), 3'd7, 1'b1, 1'b1, $urandom());
    // short counts on non-final words are taken as full, final word with no bytes
    add_word($urandom(), shf_pkg::CntOne, 1'b1, 1'b0, $urandom());
    add_word($urandom(), NoBytes, 1'b0, 1'b0, $urandom());
    add_word($urandom(), 3'd7, 1'b0, 1'b0, $urandom());
    add_word($urandom(), NoBytes, 1'b0, 1'b1, $urandom());
    // no first after a final word: carries on from the emitted hash
    add_word($urandom(), FullCount, 1'b0, 1'b1, $urandom());
    add_word($urandom(), shf_pkg::CntTwo, 1'b0, 1'b0, $urandom());
    add_word($urandom(), shf_pkg::CntThree, 1'b0, 1'b1, $urandom());
    // drained pipeline, then a first word in the middle of a message
    add_word($urandom(), FullCount, 1'b1, 1'b0, $urandom(), 1'b1);
    add_word($urandom(), FullCount, 1'b1, 1'b0, $urandom());
    add_word($urandom(), shf_pkg::CntThree, 1'b0, 1'b1, $urandom());

    // random messages, mostly well formed
    while (word_q.size() < 1000) begin
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(16, 7) : $urandom_range(6, 1);
      noisy = ($urandom_range(9, 0) == 0);
      for (int unsigned i = 0; i < len; i++) begin
        if (i + 1 < len) begin
          cnt = ($urandom_range(9, 0) == 0) ? shf_pkg::CountW'($urandom_range(7, 0))
                                            : FullCount;
        end else begin
          cnt = ($urandom_range(9, 0) == 0) ? shf_pkg::CountW'($urandom_range(7, 5))
                                            : shf_pkg::CountW'($urandom_range(4, 0));
        end
        if (noisy) begin
          add_word(pick_word(), shf_pkg::CountW'($urandom_range(7, 0)),
                   1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), pick_word());
        end else begin
          add_word(pick_word(), cnt, i == 0, i + 1 == len, pick_word(),
                   i == 0 && $urandom_range(59, 0) == 0);
        end
      end
    end
    // close with a well-formed message so the last word yields a hash
    add_word(pick_word(), shf_pkg::CountW'($urandom_range(4, 0)), 1'b1, 1'b1, pick_word());

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (word_q.size() != 0 || s_axis_tvalid || hash_q.size() != 0) @(posedge clk_i);
    repeat (TrailCycles) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("superfast_hash_stream_test: done, clean");
    end else begin
      $display("superfast_hash_stream_test: done, errors");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/shf_pkg.sv
rtl/shf_front.sv
rtl/shf_fifo.sv
rtl/shf_back.sv
rtl/superfast_hash_stream.sv
tb/superfast_hash_stream_test.sv
